// File: hw/rtl/dijkstra_shortest_paths_assert.svh
// ----------------------------------------------------------------------------
// dijkstra_shortest_paths_assert.svh
// Assertion macros shared by the shortest-path checker.
// ----------------------------------------------------------------------------
`ifndef DIJKSTRA_SHORTEST_PATHS_ASSERT_SVH
`define DIJKSTRA_SHORTEST_PATHS_ASSERT_SVH

// Same-cycle implication, disabled during reset.
`define DSP_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, disabled during reset.
`define DSP_ASSERT_NEXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// File: hw/rtl/dsp_pkg.sv
// ----------------------------------------------------------------------------
// dsp_pkg
// Shared types, widths and codes for the shortest-path engine.
// ----------------------------------------------------------------------------
package dsp_pkg;

  localparam int NUM_V  = 8;                     // vertices in the graph
  localparam int VW     = $clog2(NUM_V);         // internal vertex index width
  localparam int CW     = $clog2(NUM_V + 1);     // counter that can hold NUM_V
  localparam int AW     = $clog2(NUM_V * NUM_V); // weight matrix address width
  localparam int VF_W   = 3;                     // vertex field width on ports
  localparam int WW     = 16;                    // edge weight width
  localparam int DW     = 24;                    // distance width

  localparam logic [WW-1:0] NO_EDGE_RESET = 16'd600;

  localparam logic [1:0] REQ_CLEAR = 2'd0;
  localparam logic [1:0] REQ_WRITE = 2'd1;
  localparam logic [1:0] REQ_RUN   = 2'd2;

  typedef struct packed {
    logic [1:0]      req_type;
    logic [VF_W-1:0] from_vertex;
    logic [VF_W-1:0] to_vertex;
    logic [WW-1:0]   edge_weight;
    logic [VF_W-1:0] source_vertex;
  } req_t;

  typedef struct packed {
    logic [VF_W-1:0] vertex;
    logic [DW-1:0]   distance;
    logic            has_pred;
    logic [VF_W-1:0] pred_vertex;
    logic            last;
  } res_t;

  // Controller to datapath commands.
  typedef struct packed {
    logic          run_start;
    logic          wr_edge;
    logic          clr_matrix;
    logic          rd_en;
    logic          rd_use_k;
    logic [VW-1:0] rd_col;
    logic          ld_init;
    logic          ld_relax;
    logic [VW-1:0] ld_col;
    logic          begin_round;
    logic          out_load;
    logic [VW-1:0] out_idx;
    logic          out_last;
  } cmd_t;

  // Datapath to controller status.
  typedef struct packed {
    logic out_free;
  } stat_t;

endpackage

// File: hw/rtl/dsp_wmatrix.sv
// ----------------------------------------------------------------------------
// dsp_wmatrix
// Weight matrix memory: one write port, one registered read port, and per
// entry valid bits so a clear needs no pass over the entries.
// ----------------------------------------------------------------------------
module dsp_wmatrix (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   we,
  input  logic [dsp_pkg::AW-1:0] waddr,
  input  logic [dsp_pkg::WW-1:0] wdata,
  input  logic                   clr,
  input  logic [dsp_pkg::WW-1:0] fill_value,
  input  logic                   re,
  input  logic [dsp_pkg::AW-1:0] raddr,
  output logic [dsp_pkg::WW-1:0] rdata
);
  import dsp_pkg::*;

  localparam int DEPTH = NUM_V * NUM_V;

  logic [WW-1:0]    mem [DEPTH];
  logic [DEPTH-1:0] vld;
  logic [WW-1:0]    fill;
  logic [WW-1:0]    rdata_q;
  logic             rvld_q;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata_q <= mem[raddr];
    end
  end

  // Unwritten entries read as the fill value set at reset or the last clear.
  always_ff @(posedge clk) begin
    if (rst) begin
      vld    <= '0;
      fill   <= NO_EDGE_RESET;
      rvld_q <= 1'b0;
    end else begin
      if (clr) begin
        vld  <= '0;
        fill <= fill_value;
      end else if (we) begin
        vld[waddr] <= 1'b1;
      end
      if (re) begin
        rvld_q <= vld[raddr];
      end
    end
  end

  assign rdata = rvld_q ? rdata_q : fill;

endmodule

// File: hw/rtl/dsp_datapath.sv
// ----------------------------------------------------------------------------
// dsp_datapath
// Distance, predecessor and visited state, relaxation adder, running
// minimum tracker and the result register.
// ----------------------------------------------------------------------------
module dsp_datapath (
  input  logic                   clk,
  input  logic                   rst,
  input  dsp_pkg::req_t          req,
  input  dsp_pkg::cmd_t          cmd,
  output dsp_pkg::stat_t         stat,
  input  logic                   cfg_wr_en,
  input  logic [dsp_pkg::WW-1:0] cfg_wr_data,
  output logic                   res_valid,
  input  logic                   res_stall,
  output dsp_pkg::res_t          res
);
  import dsp_pkg::*;

  logic [WW-1:0] no_edge;
  logic [VW-1:0] src;
  logic [VW-1:0] k;
  logic [DW-1:0] dist_k;

  logic [DW-1:0] dists [NUM_V];
  logic          pval  [NUM_V];
  logic [VW-1:0] pidx  [NUM_V];
  logic [NUM_V-1:0] visited;

  logic          best_found;
  logic [VW-1:0] best_k;
  logic [DW-1:0] best_d;

  logic [AW-1:0] waddr;
  logic [AW-1:0] raddr;
  logic [VW-1:0] rrow;
  logic [WW-1:0] w;

  logic          is_src;
  logic [DW:0]   cand;
  logic          upd;
  logic [DW-1:0] nv;
  logic          elig;
  logic          take;

  assign waddr = AW'(int'(req.from_vertex) * NUM_V + int'(req.to_vertex));
  assign rrow  = cmd.rd_use_k ? k : src;
  assign raddr = AW'(int'(rrow) * NUM_V + int'(cmd.rd_col));

  dsp_wmatrix u_wmatrix (
    .clk        (clk),
    .rst        (rst),
    .we         (cmd.wr_edge),
    .waddr      (waddr),
    .wdata      (req.edge_weight),
    .clr        (cmd.clr_matrix),
    .fill_value (no_edge),
    .re         (cmd.rd_en),
    .raddr      (raddr),
    .rdata      (w)
  );

  // Value for the column whose weight just came back, and whether it
  // becomes the new minimum candidate for the next round.
  always_comb begin
    is_src = (cmd.ld_col == src);
    cand   = {1'b0, dist_k} + {{(DW - WW + 1){1'b0}}, w};
    upd    = !visited[cmd.ld_col] && ({1'b0, dists[cmd.ld_col]} > cand);
    if (cmd.ld_init) begin
      nv   = is_src ? '0 : {{(DW - WW){1'b0}}, w};
      elig = !is_src;
    end else begin
      nv   = upd ? cand[DW-1:0] : dists[cmd.ld_col];
      elig = !visited[cmd.ld_col];
    end
    take = (cmd.ld_init || cmd.ld_relax) && elig && (!best_found || (nv < best_d));
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      no_edge <= NO_EDGE_RESET;
    end else if (cfg_wr_en) begin
      no_edge <= cfg_wr_data;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_start) begin
      src <= VW'(req.source_vertex);
    end
    if (cmd.begin_round) begin
      k      <= best_k;
      dist_k <= best_d;
    end
    if (cmd.ld_init) begin
      dists[cmd.ld_col] <= nv;
      pval[cmd.ld_col]  <= (w != no_edge) && !is_src;
      pidx[cmd.ld_col]  <= src;
    end else if (cmd.ld_relax && upd) begin
      dists[cmd.ld_col] <= nv;
      pval[cmd.ld_col]  <= 1'b1;
      pidx[cmd.ld_col]  <= k;
    end
    if (take) begin
      best_k <= cmd.ld_col;
      best_d <= nv;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      visited    <= '0;
      best_found <= 1'b0;
    end else begin
      if (cmd.ld_init) begin
        visited[cmd.ld_col] <= is_src;
      end else if (cmd.begin_round) begin
        visited[best_k] <= 1'b1;
      end
      if (cmd.run_start || cmd.begin_round) begin
        best_found <= 1'b0;
      end else if (take) begin
        best_found <= 1'b1;
      end
    end
  end

  // Result register.
  assign stat.out_free = !res_valid || !res_stall;

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (cmd.out_load) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.out_load) begin
      res.vertex      <= VF_W'(cmd.out_idx);
      res.distance    <= dists[cmd.out_idx];
      res.has_pred    <= pval[cmd.out_idx];
      res.pred_vertex <= pval[cmd.out_idx] ? VF_W'(pidx[cmd.out_idx]) : '0;
      res.last        <= cmd.out_last;
    end
  end

endmodule

// File: hw/rtl/dsp_ctrl.sv
// ----------------------------------------------------------------------------
// dsp_ctrl
// Sequencer: request decode, row sweeps over the weight matrix, round
// count and result emission.
// ----------------------------------------------------------------------------
module dsp_ctrl (
  input  logic           clk,
  input  logic           rst,
  input  logic           req_valid,
  output logic           req_stall,
  input  dsp_pkg::req_t  req,
  input  dsp_pkg::stat_t stat,
  output dsp_pkg::cmd_t  cmd
);
  import dsp_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_INIT  = 3'd1;
  localparam logic [2:0] S_SEL   = 3'd2;
  localparam logic [2:0] S_RELAX = 3'd3;
  localparam logic [2:0] S_OUT   = 3'd4;

  logic [2:0]    state, state_next;
  logic [CW-1:0] col, col_next;
  logic [VW-1:0] round, round_next;
  logic [VW-1:0] oidx, oidx_next;
  logic          pend;
  logic [VW-1:0] pend_col;

  logic accept;
  logic sweep_end;

  assign req_stall = (state != S_IDLE);
  assign accept    = req_valid && !req_stall;
  assign sweep_end = (col == CW'(NUM_V));

  always_comb begin
    state_next = state;
    col_next   = col;
    round_next = round;
    oidx_next  = oidx;

    cmd             = '0;
    cmd.rd_col      = col[VW-1:0];
    cmd.rd_use_k    = (state == S_RELAX);
    cmd.ld_col      = pend_col;
    cmd.out_idx     = oidx;
    cmd.out_last    = (oidx == VW'(NUM_V - 1));

    case (state)
      S_IDLE: begin
        if (accept) begin
          case (req.req_type)
            REQ_CLEAR: cmd.clr_matrix = 1'b1;
            REQ_WRITE: cmd.wr_edge = (int'(req.from_vertex) < NUM_V) &&
                                     (int'(req.to_vertex) < NUM_V);
            REQ_RUN: begin
              if (int'(req.source_vertex) < NUM_V) begin
                cmd.run_start = 1'b1;
                col_next      = '0;
                round_next    = '0;
                state_next    = S_INIT;
              end
            end
            default: ;
          endcase
        end
      end
      S_INIT: begin
        cmd.rd_en   = !sweep_end;
        cmd.ld_init = pend;
        if (sweep_end) begin
          state_next = S_SEL;
        end else begin
          col_next = col + 1'b1;
        end
      end
      S_SEL: begin
        cmd.begin_round = 1'b1;
        col_next        = '0;
        state_next      = S_RELAX;
      end
      S_RELAX: begin
        cmd.rd_en    = !sweep_end;
        cmd.ld_relax = pend;
        if (sweep_end) begin
          if (round == VW'(NUM_V - 2)) begin
            oidx_next  = '0;
            state_next = S_OUT;
          end else begin
            round_next = round + 1'b1;
            state_next = S_SEL;
          end
        end else begin
          col_next = col + 1'b1;
        end
      end
      S_OUT: begin
        if (stat.out_free) begin
          cmd.out_load = 1'b1;
          if (oidx == VW'(NUM_V - 1)) begin
            state_next = S_IDLE;
          end else begin
            oidx_next = oidx + 1'b1;
          end
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= S_IDLE;
      col   <= '0;
      round <= '0;
      oidx  <= '0;
      pend  <= 1'b0;
    end else begin
      state <= state_next;
      col   <= col_next;
      round <= round_next;
      oidx  <= oidx_next;
      pend  <= cmd.rd_en;
    end
  end

  always_ff @(posedge clk) begin
    pend_col <= col[VW-1:0];
  end

endmodule

// File: hw/rtl/dijkstra_shortest_paths.sv
// ----------------------------------------------------------------------------
// dijkstra_shortest_paths
// Clear and edge-write transactions finish in the accept cycle. A run loads
// the source row, then does N-1 rounds of select and relax, then emits N
// results, one per vertex.
// One run at a time; the pace is set by the single weight-memory read port.
// Reset: sync, active high; the matrix reads as 600 at once (no fill pass).
// ----------------------------------------------------------------------------
module dijkstra_shortest_paths (
  input  logic                   clk,
  input  logic                   rst,
  // request channel
  input  logic                   req_valid,
  output logic                   req_stall,
  input  dsp_pkg::req_t          req,
  // result channel
  output logic                   res_valid,
  input  logic                   res_stall,
  output dsp_pkg::res_t          res,
  // no-edge weight register
  input  logic                   cfg_wr_en,
  input  logic [dsp_pkg::WW-1:0] cfg_wr_data
);
  import dsp_pkg::*;

  // Controller and datapath talk only through these two bundles.
  //   cmd : sweep reads, load strobes, round start, result load
  //   stat: result register can take a new transaction
  cmd_t  cmd;
  stat_t stat;

  // The controller decodes each request transaction. Clear and write go
  // straight to the weight memory; a run walks through:
  //   INIT  - read the source row, seed distances and predecessors
  //   SEL   - latch the minimum tracked during the previous sweep as k
  //   RELAX - read row k, relax every unvisited vertex and track the
  //           next minimum on the fly (lowest index wins a tie)
  //   OUT   - stream one result per vertex through the output register
  // The request side is stalled from run accept until the last result
  // has been loaded into the output register.
  dsp_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req       (req),
    .stat      (stat),
    .cmd       (cmd)
  );

  // Datapath holds the matrix memory, per-vertex state and the result
  // register, so a finished result can wait while a new request is taken.
  dsp_datapath u_datapath (
    .clk         (clk),
    .rst         (rst),
    .req         (req),
    .cmd         (cmd),
    .stat        (stat),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .res_valid   (res_valid),
    .res_stall   (res_stall),
    .res         (res)
  );

endmodule

// File: hw/rtl/dsp_checker.sv
// ----------------------------------------------------------------------------
// dsp_checker
// Port-level checks on the shortest-path engine, bound to the top level.
// ----------------------------------------------------------------------------
`include "dijkstra_shortest_paths_assert.svh"

module dsp_checker (
  input logic                   clk,
  input logic                   rst,
  input logic                   req_valid,
  input logic                   req_stall,
  input dsp_pkg::req_t          req,
  input logic                   res_valid,
  input logic                   res_stall,
  input dsp_pkg::res_t          res
);
  import dsp_pkg::*;

  `DSP_ASSERT_NEXT(a_res_hold, res_valid && res_stall, res_valid, "result dropped while stalled")
  `DSP_ASSERT_NEXT(a_res_stable, res_valid && res_stall, $stable(res), "stalled result changed")
  `DSP_ASSERT_NEXT(a_run_busy, req_valid && !req_stall && (req.req_type == REQ_RUN), req_stall, "run did not occupy the engine")
  `DSP_ASSERT_NOW(a_last_vertex, res_valid && res.last, res.vertex == VF_W'(NUM_V - 1), "last flag on wrong vertex")
  `DSP_ASSERT_NOW(a_pred_zero, res_valid && !res.has_pred, res.pred_vertex == '0, "predecessor set without has_pred")

endmodule

bind dijkstra_shortest_paths dsp_checker u_dsp_checker (.*);
